@@ rtl/tdg_pkg.sv @@
// ----------------------------------------------------------------------------
// Trace dependency graph package
// Shared widths, register index codes and the request, response,
// configuration and dependency row structs of the dependency graph builder.
// ----------------------------------------------------------------------------
package tdg_pkg;

    // Defaults for the top level parameters
    localparam int WORD_MAX_DEF  = 64;
    localparam int ALPHABET_DEF  = 8;
    localparam int VARIABLES_DEF = 16;

    // Fixed field widths
    localparam int LETTER_W    = 3;
    localparam int LETTER_CNT  = 1 << LETTER_W;
    localparam int COUNT_W     = 4;
    localparam int VAR_W       = 4;
    localparam int MASK_W      = 16;
    localparam int POS_W       = 6;
    localparam int PRED_W      = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int WVARS_W     = VAR_W * LETTER_CNT;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACTION_COUNT    = 2'd0,
        CFG_WRITTEN_VARS    = 2'd1,
        CFG_READ_MASKS_LOW  = 2'd2,
        CFG_READ_MASKS_HIGH = 2'd3
    } t_cfg_index;

    // Configuration register file
    typedef struct packed {
        logic [COUNT_W-1:0]    action_count;
        logic [WVARS_W-1:0]    written_vars;
        logic [CFG_DATA_W-1:0] read_masks_low;
        logic [CFG_DATA_W-1:0] read_masks_high;
    } t_cfg;

    // One input request
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                new_word;
    } t_req;

    // One response
    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [LETTER_W-1:0] letter_echo;
        logic                known;
        logic [PRED_W-1:0]   predecessors;
        logic                overflow;
    } t_rsp;

    // Dependency row of the incoming letter against every action
    typedef struct packed {
        logic                  known;
        logic [LETTER_CNT-1:0] row;
    } t_dep;

endpackage

@@ rtl/trace_dependency_graph_builder.sv @@
// ----------------------------------------------------------------------------
// Trace dependency graph builder
// Stores the letters of a word in a window and reports, for each new letter,
// its position and the mask of earlier positions it depends on.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_req  (letter, new_word)
//   response  out        o_valid / i_stall   o_rsp  (position, letter_echo,
//                                                    known, predecessors,
//                                                    overflow)
//   config    in         i_cfg_wr_en         i_cfg_index, i_cfg_wdata
//
// One request per cycle unless a stalled response holds the flow; each request
// passes the request register, then the response register. The window compare
// runs all positions at once against one dependency row, so nothing iterates.
// Reset (synchronous, active low) clears both stage valids, the window fill
// position and the configuration registers; window contents need no clear.
// A stalled response holds the request stage, which then stalls the input.
// ----------------------------------------------------------------------------
module trace_dependency_graph_builder #(
    parameter int WORD_MAX  = tdg_pkg::WORD_MAX_DEF,
    parameter int ALPHABET  = tdg_pkg::ALPHABET_DEF,
    parameter int VARIABLES = tdg_pkg::VARIABLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  tdg_pkg::t_req                    i_req,
    // response channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output tdg_pkg::t_rsp                    o_rsp,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [tdg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tdg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int PW = $clog2(WORD_MAX + 1);
    localparam int IW = $clog2(WORD_MAX);
    localparam logic [PW-1:0] POS_FULL = PW'(WORD_MAX);

    tdg_pkg::t_cfg  r_cfg;
    tdg_pkg::t_req  r_req;
    logic           r_in_valid;
    tdg_pkg::t_rsp  r_rsp;
    tdg_pkg::t_rsp  n_rsp;
    logic           r_out_valid;
    logic [PW-1:0]  r_next_pos;
    logic [PW-1:0]  n_next_pos;
    logic [tdg_pkg::LETTER_W-1:0] r_stored [WORD_MAX];

    tdg_pkg::t_dep              w_dep;
    logic                       w_adv;
    logic                       w_accept;
    logic [PW-1:0]              w_pos;
    logic [tdg_pkg::POS_W:0]    w_pos_ext;
    logic                       w_ovf;
    logic [tdg_pkg::PRED_W-1:0] w_preds;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (tdg_pkg::t_cfg_index'(i_cfg_index))
                tdg_pkg::CFG_ACTION_COUNT: begin
                    r_cfg.action_count <= i_cfg_wdata[tdg_pkg::COUNT_W-1:0];
                end
                tdg_pkg::CFG_WRITTEN_VARS: begin
                    r_cfg.written_vars <= i_cfg_wdata[tdg_pkg::WVARS_W-1:0];
                end
                tdg_pkg::CFG_READ_MASKS_LOW: begin
                    r_cfg.read_masks_low <= i_cfg_wdata;
                end
                tdg_pkg::CFG_READ_MASKS_HIGH: begin
                    r_cfg.read_masks_high <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the request stage whenever the response register is free
    assign w_adv    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !w_adv;
    assign w_accept = i_valid && !o_stall;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    // Dependency row of the letter in the request stage
    tdg_dep_row #(
        .ALPHABET  (ALPHABET),
        .VARIABLES (VARIABLES)
    ) u_dep_row (
        .i_cfg    (r_cfg),
        .i_letter (r_req.letter),
        .o_dep    (w_dep)
    );

    // Window position of this letter
    assign w_pos     = r_req.new_word ? '0 : r_next_pos;
    assign w_ovf     = (w_pos >= POS_FULL);
    assign w_pos_ext = (tdg_pkg::POS_W + 1)'(w_pos);

    // Compare every stored position below this one against the row
    for (genvar z = 0; z < tdg_pkg::PRED_W; z++) begin : g_pred
        if (z < WORD_MAX) begin : g_live
            assign w_preds[z] = (PW'(z) < w_pos) && w_dep.row[r_stored[z]];
        end else begin : g_none
            assign w_preds[z] = 1'b0;
        end
    end

    // Assemble the response
    always_comb begin
        n_rsp.position     = w_ovf ? '0 : w_pos_ext[tdg_pkg::POS_W-1:0];
        n_rsp.letter_echo  = r_req.letter;
        n_rsp.known        = w_dep.known;
        n_rsp.predecessors = w_ovf ? '0 : w_preds;
        n_rsp.overflow     = w_ovf;
        n_next_pos         = w_ovf ? POS_FULL : w_pos + PW'(1);
    end

    // Window fill position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_pos <= '0;
        end else if (w_adv) begin
            r_next_pos <= n_next_pos;
        end
    end

    // Store the letter unless the window is full
    always_ff @(posedge i_clk) begin
        if (w_adv && !w_ovf) begin
            r_stored[w_pos[IW-1:0]] <= r_req.letter;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    // Fill position never passes the window end
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_pos <= POS_FULL)
        else $error("window fill position beyond window");

    // Edges only point back to earlier positions
    a_pred_earlier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_rsp.predecessors >> o_rsp.position) == '0))
        else $error("edge from a position not before this letter");

    // Unknown letters and overflowed letters carry no edges
    a_no_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (!o_rsp.known || o_rsp.overflow)) |-> (o_rsp.predecessors == '0))
        else $error("edges on an unknown or overflowed letter");

    // An overflow leaves the window marked full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_ovf) |=> (r_next_pos == POS_FULL))
        else $error("overflow did not keep the window full");

endmodule

@@ rtl/tdg_dep_row.sv @@
// ----------------------------------------------------------------------------
// Trace dependency graph: dependency row
// For one letter, flags every defined action that it depends on: a shared
// written variable, or one action reading what the other writes.
// ----------------------------------------------------------------------------
module tdg_dep_row #(
    parameter int ALPHABET  = tdg_pkg::ALPHABET_DEF,
    parameter int VARIABLES = tdg_pkg::VARIABLES_DEF
) (
    input  tdg_pkg::t_cfg                       i_cfg,
    input  logic [tdg_pkg::LETTER_W-1:0]        i_letter,
    output tdg_pkg::t_dep                       o_dep
);

    localparam logic [tdg_pkg::MASK_W-1:0] VAR_LIM =
        (VARIABLES >= tdg_pkg::MASK_W) ? '1 : tdg_pkg::MASK_W'((1 << VARIABLES) - 1);
    localparam logic [tdg_pkg::COUNT_W-1:0] ALPHA_LIM = tdg_pkg::COUNT_W'(ALPHABET);

    logic [tdg_pkg::VAR_W-1:0]   w_wvar  [tdg_pkg::LETTER_CNT];
    logic [tdg_pkg::MASK_W-1:0]  w_rmask [tdg_pkg::LETTER_CNT];
    logic [tdg_pkg::COUNT_W-1:0] w_count;
    logic [tdg_pkg::VAR_W-1:0]   w_va;
    logic [tdg_pkg::MASK_W-1:0]  w_rma;

    // Unpack per-action written variable and read mask
    always_comb begin
        for (int k = 0; k < tdg_pkg::LETTER_CNT; k++) begin
            w_wvar[k] = i_cfg.written_vars[k*tdg_pkg::VAR_W +: tdg_pkg::VAR_W];
            if (k < tdg_pkg::LETTER_CNT / 2) begin
                w_rmask[k] = i_cfg.read_masks_low[k*tdg_pkg::MASK_W +: tdg_pkg::MASK_W]
                             & VAR_LIM;
            end else begin
                w_rmask[k] = i_cfg.read_masks_high[(k - tdg_pkg::LETTER_CNT/2)
                             * tdg_pkg::MASK_W +: tdg_pkg::MASK_W] & VAR_LIM;
            end
        end
    end

    // Clamp action count to the alphabet size
    assign w_count = (i_cfg.action_count > ALPHA_LIM) ? ALPHA_LIM : i_cfg.action_count;

    assign w_va  = w_wvar[i_letter];
    assign w_rma = w_rmask[i_letter];

    // Build the row; an unknown letter gets an empty row
    always_comb begin
        o_dep.known = {1'b0, i_letter} < w_count;
        for (int b = 0; b < tdg_pkg::LETTER_CNT; b++) begin
            o_dep.row[b] = o_dep.known
                           && (tdg_pkg::COUNT_W'(b) < w_count)
                           && (w_rmask[b][w_va] || w_rma[w_wvar[b]] || (w_va == w_wvar[b]));
        end
    end

endmodule
